// ===== rtl/edge_event_history_ring_defines.svh =====
// ----------------------------------------------------------------------------
// Edge event history ring: assertion macros
// Shared concurrent assertion forms; they compile to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef EDGE_EVENT_HISTORY_RING_DEFINES_SVH
`define EDGE_EVENT_HISTORY_RING_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define EEHR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("edge event history ring: check failed");
// Next-cycle implication, disabled while reset is asserted.
`define EEHR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("edge event history ring: check failed");
`else
`define EEHR_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define EEHR_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/eehr_pkg.sv =====
// ----------------------------------------------------------------------------
// Edge event history ring package
// Entry type and cell operation codes shared by the cell and the top level.
// ----------------------------------------------------------------------------
package eehr_pkg;

  // One logged level change.
  typedef struct packed {
    logic [31:0] time_ms;
    logic        level;
  } entry_t;

  // What a cell loads at the next clock edge.
  typedef logic [1:0] cell_op_t;

  localparam cell_op_t OP_HOLD = 2'd0;  // keep the stored entry
  localparam cell_op_t OP_NEXT = 2'd1;  // take the entry of the next cell
  localparam cell_op_t OP_NEW  = 2'd2;  // take the freshly logged entry
  localparam cell_op_t OP_WRAP = 2'd3;  // take the entry of cell zero

endpackage

// ===== rtl/eehr_cell.sv =====
// ----------------------------------------------------------------------------
// Edge event history ring cell
// Holds one log entry and loads from its neighbor, from the head cell or
// from the new entry, as its operation code says.
// ----------------------------------------------------------------------------
module eehr_cell (
  input  logic              clk,
  input  eehr_pkg::cell_op_t op,
  input  eehr_pkg::entry_t   next_in,
  input  eehr_pkg::entry_t   head_in,
  input  eehr_pkg::entry_t   new_in,
  output eehr_pkg::entry_t   data_r
);
  import eehr_pkg::*;

  entry_t data_nxt;

  // Select the value loaded at the next edge.
  always_comb begin
    case (op)
      OP_HOLD: data_nxt = data_r;
      OP_NEXT: data_nxt = next_in;
      OP_NEW:  data_nxt = new_in;
      OP_WRAP: data_nxt = head_in;
      default: data_nxt = data_r;
    endcase
  end

  // Payload storage needs no reset.
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

// ===== rtl/edge_event_history_ring.sv =====
// ----------------------------------------------------------------------------
// Edge event history ring
// Logs level changes of one pin with timestamps in a chain of DEPTH cells
// and dumps them oldest first on request.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats carry in_func, in_raw_level and in_time_ms. A sample beat
//   (func 0) gives no result; the first sample after reset only sets
//   the baseline level. Each later level change is stored in the cell
//   chain, cell zero holding the oldest entry; once the chain is full,
//   the chain shifts by one and the oldest entry drops out.
//   A dump beat (func 1) gives one result beat per held entry, oldest
//   first, with out_last_of_run on the final one, or a single empty
//   marker when nothing is held. The chain rotates by one cell per
//   emitted result, and in_ready is low until the dump is done, also
//   while the receiver stalls. Results leave through an output register.
//   Samples sustain one beat per cycle while no dump is in progress.
//   A stalled receiver holds the output register; a sample may still be
//   accepted while a result waits. Reset empties the log and drops any
//   dump in progress.
// ----------------------------------------------------------------------------
`include "edge_event_history_ring_defines.svh"

module edge_event_history_ring #(
  parameter int DEPTH = 12
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_func,
  input  logic [7:0]                       in_raw_level,
  input  logic [31:0]                      in_time_ms,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [31:0]                      out_rec_time,
  output logic                             out_rec_level,
  output logic [$clog2(DEPTH+1)-1:0]       out_entry_count,
  output logic                             out_is_empty,
  output logic                             out_last_of_run
);
  import eehr_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  logic          baseline_r, baseline_nxt;
  logic          last_level_r, last_level_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          busy_r, busy_nxt;
  logic [CW-1:0] step_r, step_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [31:0]   out_time_r, out_time_nxt;
  logic          out_level_r, out_level_nxt;
  logic [CW-1:0] out_count_r, out_count_nxt;
  logic          out_empty_r, out_empty_nxt;
  logic          out_last_r, out_last_nxt;

  logic          accept;
  logic          sample_lvl;
  logic          do_write;
  logic          slot_free;
  logic          do_rotate;
  logic          last_step;
  entry_t        new_entry;
  entry_t        cell_q  [DEPTH];
  cell_op_t      cell_op [DEPTH];

  assign in_ready   = !busy_r;
  assign accept     = in_valid && in_ready;
  assign sample_lvl = |in_raw_level;
  assign do_write   = accept && !in_func && baseline_r && (sample_lvl != last_level_r);
  assign slot_free  = !out_valid_r || out_ready;
  assign do_rotate  = busy_r && slot_free && (count_r != '0);
  assign last_step  = (step_r == count_r - CW'(1));
  assign new_entry  = '{time_ms: in_time_ms, level: sample_lvl};

  // Per-cell operation: append, shift when full, or rotate during a dump.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cell_op[i] = OP_HOLD;
      if (do_write) begin
        if (count_r != DEPTH_C) begin
          if (count_r == CW'(i)) cell_op[i] = OP_NEW;
        end else if (i == DEPTH - 1) begin
          cell_op[i] = OP_NEW;
        end else begin
          cell_op[i] = OP_NEXT;
        end
      end else if (do_rotate) begin
        if (CW'(i) == count_r - CW'(1)) cell_op[i] = OP_WRAP;
        else if (CW'(i) < count_r) cell_op[i] = OP_NEXT;
      end
    end
  end

  // The chain of cells; the last cell's neighbor input is never selected.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    if (g < DEPTH - 1) begin : g_mid
      eehr_cell u_cell (
        .clk     (clk),
        .op      (cell_op[g]),
        .next_in (cell_q[g+1]),
        .head_in (cell_q[0]),
        .new_in  (new_entry),
        .data_r  (cell_q[g])
      );
    end else begin : g_end
      eehr_cell u_cell (
        .clk     (clk),
        .op      (cell_op[g]),
        .next_in (cell_q[0]),
        .head_in (cell_q[0]),
        .new_in  (new_entry),
        .data_r  (cell_q[g])
      );
    end
  end

  // Control: baseline, level tracking, count and dump sequencing.
  always_comb begin
    baseline_nxt   = baseline_r;
    last_level_nxt = last_level_r;
    count_nxt      = count_r;
    busy_nxt       = busy_r;
    step_nxt       = step_r;
    if (accept && !in_func) begin
      baseline_nxt   = 1'b1;
      last_level_nxt = sample_lvl;
    end
    if (do_write && count_r != DEPTH_C) count_nxt = count_r + CW'(1);
    if (accept && in_func) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
    end
    if (busy_r && slot_free) begin
      if (count_r == '0 || last_step) begin
        busy_nxt = 1'b0;
        step_nxt = '0;
      end else begin
        step_nxt = step_r + CW'(1);
      end
    end
  end

  // Output register: load a result beat when the slot is free.
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    out_time_nxt  = out_time_r;
    out_level_nxt = out_level_r;
    out_count_nxt = out_count_r;
    out_empty_nxt = out_empty_r;
    out_last_nxt  = out_last_r;
    if (busy_r && slot_free) begin
      out_valid_nxt = 1'b1;
      if (count_r == '0) begin
        out_time_nxt  = '0;
        out_level_nxt = 1'b0;
        out_count_nxt = '0;
        out_empty_nxt = 1'b1;
        out_last_nxt  = 1'b1;
      end else begin
        out_time_nxt  = cell_q[0].time_ms;
        out_level_nxt = cell_q[0].level;
        out_count_nxt = count_r;
        out_empty_nxt = 1'b0;
        out_last_nxt  = last_step;
      end
    end
  end

  // Control registers are reset; output payload is not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      baseline_r   <= 1'b0;
      last_level_r <= 1'b0;
      count_r      <= '0;
      busy_r       <= 1'b0;
      step_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      baseline_r   <= baseline_nxt;
      last_level_r <= last_level_nxt;
      count_r      <= count_nxt;
      busy_r       <= busy_nxt;
      step_r       <= step_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_time_r  <= out_time_nxt;
    out_level_r <= out_level_nxt;
    out_count_r <= out_count_nxt;
    out_empty_r <= out_empty_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_rec_time    = out_time_r;
  assign out_rec_level   = out_level_r;
  assign out_entry_count = out_count_r;
  assign out_is_empty    = out_empty_r;
  assign out_last_of_run = out_last_r;

  // Checks on the log and the dump sequencer.
  `EEHR_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_r <= DEPTH_C)
  `EEHR_ASSERT_IMP(a_step_bound, clk, rst_n, busy_r && step_r != '0, step_r < count_r)
  `EEHR_ASSERT_NXT(a_dump_starts, clk, rst_n, accept && in_func, busy_r || out_valid_r)
  `EEHR_ASSERT_IMP(a_empty_marker, clk, rst_n, out_valid_r && out_empty_r,
                   out_last_r && out_count_r == '0)

endmodule
